[hdl/bfm_pkg.sv]
// shared types, constants and helpers for the 3x3 mirrored box filter
`default_nettype none

package bfm_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int RING_ROWS    = 3;
   localparam int DIM_W        = 11;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT) + 1;
   localparam int OUT_ROW_W    = $clog2(HEIGHT_LIMIT);
   localparam int BANK_W       = $clog2(RING_ROWS);
   localparam int PIX_W        = 8;
   localparam int COLSUM_W     = PIX_W + 2;
   localparam int SUM_W        = COLSUM_W + 2;
   localparam int CSR_IDX_W    = 1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(320);
   localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(HEIGHT_LIMIT);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [1:0] WGT_NONE   = 2'd0;
   localparam logic [1:0] WGT_SINGLE = 2'd1;
   localparam logic [1:0] WGT_DOUBLE = 2'd2;

   // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
   localparam int              DIV9_MUL_W = 13;
   localparam int              DIV9_SHIFT = 16;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(7282);

   typedef struct packed {
      logic             cmd;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic                          wr_en;
      logic [BANK_W-1:0]             wr_bank;
      logic [COL_W-1:0]              wr_addr;
      logic [PIX_W-1:0]              wr_data;
      logic                          emit;
      logic                          first;
      logic [COL_W-1:0]              rd_col;
      logic [RING_ROWS-1:0][1:0]     wgt;
      logic                          last;
   } cmd_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) r = DIM_MIN;
      if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [SUM_W+DIV9_MUL_W-1:0] p;
      p = (SUM_W + DIV9_MUL_W)'(s) * (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
      return p[DIV9_SHIFT +: PIX_W];
   endfunction

   function automatic logic [BANK_W-1:0] bank_step(input logic [BANK_W-1:0] b);
      logic [BANK_W-1:0] r;
      if (b == BANK_W'(RING_ROWS - 1)) r = '0;
      else r = b + BANK_W'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/bfm_front.sv]
// front end: geometry registers, stream counters and per-beat classification
`default_nettype none

module bfm_front import bfm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   input  wire logic                 q_full,
   output logic                      q_push,
   output cmd_type                   q_data
);

   logic [DIM_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [ROW_W-1:0]     in_row_ff, in_row_in;
   logic [BANK_W-1:0]    in_bank_ff, in_bank_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic [BANK_W-1:0]    out_bank_ff, out_bank_in;

   logic accept, in_frame, active, emit, col_wrap, out_last_col, out_last_row, last;
   logic [BANK_W-1:0] nb, pb;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign in_frame  = in_row_ff < ROW_W'(h_ff);
   assign active    = accept && !(in_frame && req_data.cmd);
   assign emit      = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign col_wrap  = (DIM_W'(in_col_ff) + DIM_W'(1)) >= w_ff;
   assign out_last_col = (DIM_W'(out_col_ff) + DIM_W'(1)) >= w_ff;
   assign out_last_row = (DIM_W'(out_row_ff) + DIM_W'(1)) >= h_ff;
   assign last      = out_last_col && out_last_row;
   assign nb        = bank_step(out_bank_ff);
   assign pb        = bank_step(nb);

   always_comb begin
      q_push          = active;
      q_data.wr_en    = in_frame;
      q_data.wr_bank  = in_bank_ff;
      q_data.wr_addr  = in_col_ff;
      q_data.wr_data  = req_data.pixel_in;
      q_data.emit     = emit;
      q_data.first    = out_col_ff == '0;
      q_data.last     = last;
      if (out_col_ff == '0) begin
         q_data.rd_col = '0;
      end else if (out_last_col) begin
         q_data.rd_col = COL_W'(w_ff - DIM_W'(2));
      end else begin
         q_data.rd_col = out_col_ff + COL_W'(1);
      end
      for (int b = 0; b < RING_ROWS; b++) begin
         if (BANK_W'(b) == out_bank_ff) begin
            q_data.wgt[b] = WGT_SINGLE;
         end else if (BANK_W'(b) == nb) begin
            q_data.wgt[b] = (out_row_ff == '0) ? WGT_DOUBLE :
                            (out_last_row ? WGT_NONE : WGT_SINGLE);
         end else if (BANK_W'(b) == pb) begin
            q_data.wgt[b] = (out_row_ff == '0) ? WGT_NONE :
                            (out_last_row ? WGT_DOUBLE : WGT_SINGLE);
         end else begin
            q_data.wgt[b] = WGT_NONE;
         end
      end
   end

   always_comb begin
      w_in        = w_ff;
      h_in        = h_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_bank_in  = in_bank_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_bank_in = out_bank_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  w_in = clamp_dim(csr_wdata, WIDTH_MAX);
            REG_IMAGE_HEIGHT: h_in = clamp_dim(csr_wdata, HEIGHT_MAX);
            default: ;
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         in_bank_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_bank_in = '0;
      end else if (active) begin
         if (col_wrap) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + ROW_W'(1);
            in_bank_in = bank_step(in_bank_ff);
         end else begin
            in_col_in  = in_col_ff + COL_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               in_bank_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_bank_in = '0;
            end else if (out_last_col) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + OUT_ROW_W'(1);
               out_bank_in = nb;
            end else begin
               out_col_in  = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= WIDTH_RESET;
         h_ff        <= HEIGHT_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_bank_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_bank_ff <= '0;
      end else begin
         w_ff        <= w_in;
         h_ff        <= h_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_bank_ff  <= in_bank_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_bank_ff <= out_bank_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bfm_queue.sv]
// four-entry command queue between front and back
`default_nettype none

module bfm_queue import bfm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output cmd_type      pop_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = count_ff == (PTR_W + 1)'(DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + PTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + PTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (PTR_W + 1)'(1);
      if (!do_push && do_pop) count_in = count_ff - (PTR_W + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bfm_back.sv]
// back end: row banks, column window, sum and divide by nine
`default_nettype none

module bfm_back import bfm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_not_empty,
   input  wire cmd_type q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [PIX_W-1:0] bank_mem [RING_ROWS][MAX_WIDTH];

   logic                          adv;
   logic                          a_vld_ff;
   cmd_type                       a_cmd_ff;
   logic [RING_ROWS-1:0][PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic [COLSUM_W-1:0]           cs_a, cs_b;
   logic                          b_vld_ff, b_last_ff;
   logic [COLSUM_W-1:0]           win_l_ff, win_m_ff, win_r_ff;
   logic                          c_vld_ff, c_last_ff;
   logic [SUM_W-1:0]              c_sum_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign q_pop     = adv && q_not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row banks with write-through on a same-address read
   always_ff @(posedge clock) begin
      for (int b = 0; b < RING_ROWS; b++) begin
         if (q_pop) begin
            if (q_data.wr_en && q_data.wr_bank == BANK_W'(b)) begin
               bank_mem[b][q_data.wr_addr] <= q_data.wr_data;
            end
            if (q_data.wr_en && q_data.wr_bank == BANK_W'(b)
                && q_data.wr_addr == q_data.rd_col) begin
               rd_a_ff[b] <= q_data.wr_data;
            end else begin
               rd_a_ff[b] <= bank_mem[b][q_data.rd_col];
            end
            if (q_data.wr_en && q_data.wr_bank == BANK_W'(b)
                && q_data.wr_addr == COL_W'(1)) begin
               rd_b_ff[b] <= q_data.wr_data;
            end else begin
               rd_b_ff[b] <= bank_mem[b][COL_W'(1)];
            end
         end
      end
   end

   always_comb begin
      cs_a = '0;
      cs_b = '0;
      for (int b = 0; b < RING_ROWS; b++) begin
         case (a_cmd_ff.wgt[b])
            WGT_SINGLE: begin
               cs_a = cs_a + COLSUM_W'(rd_a_ff[b]);
               cs_b = cs_b + COLSUM_W'(rd_b_ff[b]);
            end
            WGT_DOUBLE: begin
               cs_a = cs_a + (COLSUM_W'(rd_a_ff[b]) << 1);
               cs_b = cs_b + (COLSUM_W'(rd_b_ff[b]) << 1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (q_pop) a_cmd_ff <= q_data;
         b_last_ff <= a_cmd_ff.last;
         if (a_vld_ff && a_cmd_ff.emit) begin
            if (a_cmd_ff.first) begin
               win_l_ff <= cs_b;
               win_m_ff <= cs_a;
               win_r_ff <= cs_b;
            end else begin
               win_l_ff <= win_m_ff;
               win_m_ff <= win_r_ff;
               win_r_ff <= cs_a;
            end
         end
         c_sum_ff  <= SUM_W'(win_l_ff) + SUM_W'(win_m_ff) + SUM_W'(win_r_ff);
         c_last_ff <= b_last_ff;
         rsp_data_ff.pixel_out  <= div9(c_sum_ff);
         rsp_data_ff.frame_last <= c_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff     <= q_pop;
         b_vld_ff     <= a_vld_ff && a_cmd_ff.emit;
         c_vld_ff     <= b_vld_ff;
         rsp_valid_ff <= c_vld_ff;
      end
   end

endmodule

`default_nettype wire

[hdl/box_filter_3x3_mirror_unit.sv]
// top level of the streaming 3x3 mirrored box filter
//
//   port group   dir   handshake             beat
//   req_*        in    req_valid/req_stall   req_type: cmd, pixel_in
//   rsp_*        out   rsp_valid/rsp_stall   rsp_type: pixel_out, frame_last
//   csr_*        in    csr_wr_en             index 0 width, 1 height
//
// one beat per cycle in and out while the queue has room and rsp_stall is low
// the first result of a frame follows beat width+1 counted from zero, flush beats push out the last row
// reset clears counters, queue and valids and sets width and height to 320; no clearing pass
// rsp_stall freezes the back end; the four-entry queue keeps req open until it fills
`default_nettype none

module box_filter_3x3_mirror_unit import bfm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data
);

   logic    q_full, q_push, q_pop, q_not_empty;
   cmd_type q_in, q_out;

   bfm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   bfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   bfm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_out),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[dv/box_filter_3x3_mirror_unit_test.sv]
// testbench for the 3x3 mirrored box filter: streams frames and checks every result beat
`timescale 1ns / 1ps

module box_filter_3x3_mirror_unit_test import bfm_pkg::*; ();

   localparam logic CMD_PIXEL     = 1'b0;
   localparam logic CMD_FLUSH     = 1'b1;
   localparam int   PIX_UNIFORM   = 0;
   localparam int   PIX_EXTREME   = 1;
   localparam int   PIX_SATURATED = 2;
   localparam int   NEIGHBORS     = 9;
   localparam int   RING_SIZE     = RING_ROWS * MAX_WIDTH;
   localparam int   SETTLE_CYCLES = 16;
   localparam int   STUCK_LIMIT   = 2000;
   localparam int   REPORT_LIMIT  = 10;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;

   box_filter_3x3_mirror_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predictor state
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [PIX_W-1:0] ring_pixels [RING_SIZE];
   int unsigned      in_col;
   int unsigned      in_row;
   int unsigned      out_col;
   int unsigned      out_row;
   rsp_type          mean_queue [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int beats_sent;
   int means_checked;
   int frames_closed;
   int mismatch_count;
   int stuck_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned used_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
      int unsigned r;
      r = v;
      if (r < 3) r = 3;
      if (r > hi) r = hi;
      return r;
   endfunction

   // position given as value + 1; one step outside reflects past the edge pixel
   function automatic int unsigned mirror(input int unsigned p1, input int unsigned lim);
      if (p1 == 0) return 1;
      if (p1 > lim) return lim - 2;
      return p1 - 1;
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
      logic [PIX_W-1:0] p;
      case (mode)
         PIX_UNIFORM: p = PIX_W'($urandom_range(255));
         PIX_EXTREME: p = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
         default:     p = 8'hFF;
      endcase
      return p;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return DIM_W'($urandom_range(2));
      if (r == 1) return DIM_W'($urandom_range(3 * hi, hi + 1));
      return DIM_W'($urandom_range(hi, 3));
   endfunction

   task automatic restart_counters();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endtask

   task automatic predict_mean(input req_type beat);
      int unsigned w, h, total, rr, cc, r, c;
      logic        emit_now;
      logic        last;
      rsp_type     mean;
      w = used_dim(width_reg, MAX_WIDTH);
      h = used_dim(height_reg, HEIGHT_LIMIT);
      if (in_row < h) begin
         if (beat.cmd == CMD_FLUSH) return;
         ring_pixels[(in_row % RING_ROWS) * MAX_WIDTH + in_col] = beat.pixel_in;
      end
      emit_now = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit_now) return;
      total = 0;
      for (rr = 0; rr < 3; rr++) begin
         for (cc = 0; cc < 3; cc++) begin
            r = mirror(out_row + rr, h);
            c = mirror(out_col + cc, w);
            total += ring_pixels[(r % RING_ROWS) * MAX_WIDTH + c];
         end
      end
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      mean.pixel_out  = PIX_W'(total / NEIGHBORS);
      mean.frame_last = last;
      mean_queue.push_back(mean);
      if (last) begin
         restart_counters();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pixel);
      req_type beat;
      beat.cmd      = cmd;
      beat.pixel_in = pixel;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_mean(beat);
      beats_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mean_queue.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_reg  = w;
      height_reg = h;
      restart_counters();
   endtask

   // a short pixel count leaves the frame open; rough adds early flushes, late pixels and drains
   task automatic send_frame(input int unsigned pixels, input int mode, input bit rough);
      int unsigned w, h, i;
      w = used_dim(width_reg, MAX_WIDTH);
      h = used_dim(height_reg, HEIGHT_LIMIT);
      for (i = 0; i < pixels; i++) begin
         if (rough && $urandom_range(19) == 0) send_beat(CMD_FLUSH, PIX_W'($urandom));
         send_beat(CMD_PIXEL, pick_pixel(mode));
         if (rough && $urandom_range(49) == 0) hold_until_drained();
      end
      if (pixels < w * h) return;
      for (i = 0; i <= w; i++) begin
         send_beat((rough && $urandom_range(9) == 0) ? CMD_PIXEL : CMD_FLUSH, PIX_W'($urandom));
      end
      if (rough && $urandom_range(3) == 0) send_beat(CMD_FLUSH, PIX_W'($urandom));
   endtask

   task automatic test_smallest_frame();
      int i;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_geometry(DIM_W'(3), DIM_W'(3));
      for (i = 0; i < 9; i++) begin
         send_beat(CMD_PIXEL, (i % 2 == 0) ? 8'h00 : 8'hFF);
         if (i == 3) send_beat(CMD_FLUSH, 8'hFF);
      end
      repeat (3) send_beat(CMD_FLUSH, 8'h00);
      // pixel after the frame is complete counts as a flush
      send_beat(CMD_PIXEL, 8'hFF);
      send_beat(CMD_FLUSH, 8'h55);
   endtask

   task automatic test_clamped_geometry();
      write_geometry(DIM_W'(1), DIM_W'(2));
      send_frame(9, PIX_SATURATED, 1'b0);
   endtask

   task automatic test_restart_mid_frame();
      write_geometry(DIM_W'(5), DIM_W'(4));
      send_frame(12, PIX_UNIFORM, 1'b0);
      hold_until_drained();
      send_frame(3, PIX_EXTREME, 1'b0);
      write_geometry(DIM_W'(4), DIM_W'(5));
      send_frame(20, PIX_UNIFORM, 1'b0);
   endtask

   task automatic test_widest_row();
      sender_idle_pct    = 0;
      receiver_stall_pct = 55;
      write_geometry(DIM_W'(2047), DIM_W'(0));
      send_frame(MAX_WIDTH + 64, PIX_UNIFORM, 1'b0);
   endtask

   task automatic test_tallest_frame();
      sender_idle_pct    = 32;
      receiver_stall_pct = 32;
      write_geometry(DIM_W'(0), DIM_W'(2047));
      send_frame(60, PIX_EXTREME, 1'b0);
   endtask

   task automatic test_random_frames(input int send_pct, input int stall_pct, input int budget);
      int          sent, kind;
      int unsigned w, h, n;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < budget) begin
         write_geometry(pick_dim(12), pick_dim(8));
         w    = used_dim(width_reg, MAX_WIDTH);
         h    = used_dim(height_reg, HEIGHT_LIMIT);
         kind = $urandom_range(9);
         if (kind == 0) begin
            n = $urandom_range(30, 4);
            repeat (n) begin
               send_beat(($urandom_range(1) == 0) ? CMD_PIXEL : CMD_FLUSH, PIX_W'($urandom));
            end
            sent += n;
         end else if (kind == 1) begin
            n = $urandom_range(w * h - 1, 1);
            send_frame(n, $urandom_range(2), 1'b1);
            sent += n;
         end else begin
            send_frame(w * h, $urandom_range(2), 1'b1);
            sent += w * h + w + 1;
         end
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mean_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result beat: pixel_out %0d frame_last %0d",
                        rsp_data.pixel_out, rsp_data.frame_last);
         end else begin
            want = mean_queue.pop_front();
            means_checked++;
            if (want.frame_last) frames_closed++;
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d: expected pixel_out %0d frame_last %0d, got %0d %0d",
                           means_checked, want.pixel_out, want.frame_last,
                           rsp_data.pixel_out, rsp_data.frame_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no beat moved for %0d cycles", STUCK_LIMIT);
         $display("[box_filter_3x3_mirror_unit] ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_data           = '0;
      rsp_stall          = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      beats_sent         = 0;
      means_checked      = 0;
      frames_closed      = 0;
      mismatch_count     = 0;
      stuck_cycles       = 0;
      width_reg          = WIDTH_RESET;
      height_reg         = HEIGHT_RESET;
      restart_counters();
      foreach (ring_pixels[k]) ring_pixels[k] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_smallest_frame();
      test_clamped_geometry();
      test_restart_mid_frame();
      test_widest_row();
      test_tallest_frame();
      test_random_frames(0, 0, 200);
      test_random_frames(55, 0, 200);
      test_random_frames(0, 55, 200);
      test_random_frames(32, 32, 200);
      settle();

      $display("sent %0d request beats, checked %0d filtered pixels over %0d closed frames",
               beats_sent, means_checked, frames_closed);
      $display("geometry from clamped 3x3 up to the 1024 limits, with restarts, %s",
               "early flushes, late pixels and idling on both sides");
      if (mismatch_count == 0 && mean_queue.size() == 0) begin
         $display("[box_filter_3x3_mirror_unit] OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatch_count, mean_queue.size());
         $display("[box_filter_3x3_mirror_unit] ERROR");
      end
      $finish;
   end

endmodule
